[hdl/keypad_code_lock_controller_macros.svh]
// Assertion helpers for the lock controller core.
// Each expects clk and arst_n in the scope of the module that uses it.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KCLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define KCLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/kclc_pkg.sv]
package kclc_pkg;

	// Default geometry
	localparam int NUM_BUTTONS_DEF  = 4;
	localparam int CODE_LENGTH_DEF  = 4;
	localparam int HISTORY_BITS_DEF = 8;

	// Fixed field widths
	localparam int TIMER_W = 8;
	localparam int FAIL_W  = 3;
	localparam int DIGIT_W = 3;
	localparam int IDX_W   = 3;
	localparam int MODE_W  = 4;

	// History value that marks a press: low samples, then two high ones
	localparam logic [15:0] PRESS_PATTERN = 16'h0003;

	localparam logic [TIMER_W-1:0] TICK_MAX  = 8'hFF;
	localparam logic [FAIL_W-1:0]  FAIL_SAT  = 3'd7;

	// Register reset values
	localparam logic [31:0]        UNLOCK_RESET      = 32'd668;
	localparam logic [31:0]        RESET_CODE_RESET  = 32'd585;
	localparam logic [TIMER_W-1:0] START_DELAY_RESET = 8'd40;
	localparam logic [TIMER_W-1:0] ENTRY_TMO_RESET   = 8'd60;
	localparam logic [TIMER_W-1:0] OPEN_HOLD_RESET   = 8'd40;
	localparam logic [TIMER_W-1:0] ALARM_RESET       = 8'd20;
	localparam logic [TIMER_W-1:0] RESET_HOLD_RESET  = 8'd20;
	localparam logic [FAIL_W-1:0]  MAX_FAIL_RESET    = 3'd3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_UNLOCK_CODE = 3'd0;
	localparam logic [IDX_W-1:0] REG_RESET_CODE  = 3'd1;
	localparam logic [IDX_W-1:0] REG_START_DELAY = 3'd2;
	localparam logic [IDX_W-1:0] REG_ENTRY_TMO   = 3'd3;
	localparam logic [IDX_W-1:0] REG_OPEN_HOLD   = 3'd4;
	localparam logic [IDX_W-1:0] REG_ALARM       = 3'd5;
	localparam logic [IDX_W-1:0] REG_RESET_HOLD  = 3'd6;
	localparam logic [IDX_W-1:0] REG_MAX_FAIL    = 3'd7;

	typedef struct packed {
		logic [TIMER_W-1:0] start_delay;
		logic [TIMER_W-1:0] entry_timeout;
		logic [TIMER_W-1:0] open_hold;
		logic [TIMER_W-1:0] alarm;
		logic [TIMER_W-1:0] reset_hold;
		logic [FAIL_W-1:0]  max_fail;
	} timers_t;

	typedef struct packed {
		logic               hit;
		logic [DIGIT_W-1:0] digit;
	} press_t;

	typedef struct packed {
		logic              door;
		logic              buzz;
		logic              ready;
		logic              entry;
		logic [MODE_W-1:0] mode;
		logic [2:0]        digits;
		logic [FAIL_W-1:0] fails;
	} status_t;

	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
		sat_inc = (v == TICK_MAX) ? v : v + 1'b1;
	endfunction

endpackage

[hdl/kclc_cfg_regs.sv]
module kclc_cfg_regs #(
	parameter int CODE_LENGTH = kclc_pkg::CODE_LENGTH_DEF,
	parameter int CFG_W       = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kclc_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [CFG_W-1:0]               cfg_wdata,
	output logic [3*CODE_LENGTH-1:0]       unlock_code,
	output logic [3*CODE_LENGTH-1:0]       reset_code,
	output kclc_pkg::timers_t              timers
);

	localparam int CODE_BITS = 3 * CODE_LENGTH;

	logic [CODE_BITS-1:0] unlock_q;
	logic [CODE_BITS-1:0] rcode_q;
	kclc_pkg::timers_t    timers_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlock_q               <= CODE_BITS'(kclc_pkg::UNLOCK_RESET);
			rcode_q                <= CODE_BITS'(kclc_pkg::RESET_CODE_RESET);
			timers_q.start_delay   <= kclc_pkg::START_DELAY_RESET;
			timers_q.entry_timeout <= kclc_pkg::ENTRY_TMO_RESET;
			timers_q.open_hold     <= kclc_pkg::OPEN_HOLD_RESET;
			timers_q.alarm         <= kclc_pkg::ALARM_RESET;
			timers_q.reset_hold    <= kclc_pkg::RESET_HOLD_RESET;
			timers_q.max_fail      <= kclc_pkg::MAX_FAIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				kclc_pkg::REG_UNLOCK_CODE: unlock_q <= cfg_wdata[CODE_BITS-1:0];
				kclc_pkg::REG_RESET_CODE:  rcode_q  <= cfg_wdata[CODE_BITS-1:0];
				kclc_pkg::REG_START_DELAY: timers_q.start_delay   <= cfg_wdata[7:0];
				kclc_pkg::REG_ENTRY_TMO:   timers_q.entry_timeout <= cfg_wdata[7:0];
				kclc_pkg::REG_OPEN_HOLD:   timers_q.open_hold     <= cfg_wdata[7:0];
				kclc_pkg::REG_ALARM:       timers_q.alarm         <= cfg_wdata[7:0];
				kclc_pkg::REG_RESET_HOLD:  timers_q.reset_hold    <= cfg_wdata[7:0];
				kclc_pkg::REG_MAX_FAIL:    timers_q.max_fail      <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	assign unlock_code = unlock_q;
	assign reset_code  = rcode_q;
	assign timers      = timers_q;

endmodule

[hdl/kclc_keyscan.sv]
module kclc_keyscan #(
	parameter int NUM_BUTTONS  = kclc_pkg::NUM_BUTTONS_DEF,
	parameter int HISTORY_BITS = kclc_pkg::HISTORY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   scan_en,
	input  logic [NUM_BUTTONS-1:0] levels,
	output kclc_pkg::press_t       press
);

	localparam logic [HISTORY_BITS-1:0] PATTERN = HISTORY_BITS'(kclc_pkg::PRESS_PATTERN);

	logic [HISTORY_BITS-1:0] hist_q [NUM_BUTTONS];
	logic [HISTORY_BITS-1:0] hist_d [NUM_BUTTONS];

	// Shift each level in; the highest button that matches wins.
	always_comb begin
		press = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			hist_d[b] = {hist_q[b][HISTORY_BITS-2:0], levels[b]};
			if (hist_d[b] == PATTERN) begin
				press.hit   = 1'b1;
				press.digit = kclc_pkg::DIGIT_W'(b + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				hist_q[b] <= '1;
			end
		end else if (scan_en) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				hist_q[b] <= hist_d[b];
			end
		end
	end

endmodule

[hdl/kclc_core.sv]
`include "keypad_code_lock_controller_macros.svh"

module kclc_core #(
	parameter int CODE_LENGTH = kclc_pkg::CODE_LENGTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  kclc_pkg::press_t         press,
	input  logic [3*CODE_LENGTH-1:0] unlock_code,
	input  logic [3*CODE_LENGTH-1:0] reset_code,
	input  kclc_pkg::timers_t        timers,
	output logic                     scan_en,
	output kclc_pkg::status_t        status
);

	localparam int CODE_BITS = 3 * CODE_LENGTH;
	localparam int CNT_W     = ($clog2(CODE_LENGTH + 1) > 3) ? $clog2(CODE_LENGTH + 1) : 3;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

	typedef enum logic [kclc_pkg::MODE_W-1:0] {
		S_START   = 4'd0,
		S_DELAY   = 4'd1,
		S_ENTRY   = 4'd2,
		S_CHECK   = 4'd3,
		S_OPEN    = 4'd4,
		S_HOLD    = 4'd5,
		S_ALARM   = 4'd6,
		S_RENTRY  = 4'd7,
		S_RVERIFY = 4'd8
	} state_t;

	state_t                          state_q, state_d;
	logic [kclc_pkg::TIMER_W-1:0]    tick_q, tick_d, tick_b;
	logic [CODE_BITS-1:0]            hist_q, hist_d;
	logic [CNT_W-1:0]                cnt_q, cnt_d;
	logic [kclc_pkg::FAIL_W-1:0]     fail_q, fail_d, fail_b;
	logic                            door_q, door_d;
	logic                            buzz_q, buzz_d;
	logic                            ready_q, ready_d;
	logic                            entry_q, entry_d;

	assign scan_en = step && (state_q == S_ENTRY || state_q == S_RENTRY);

	always_comb begin
		state_d = state_q;
		tick_d  = tick_q;
		tick_b  = tick_q;
		hist_d  = hist_q;
		cnt_d   = cnt_q;
		fail_d  = fail_q;
		fail_b  = fail_q;
		door_d  = door_q;
		buzz_d  = buzz_q;
		ready_d = ready_q;
		entry_d = entry_q;
		unique case (state_q)
			S_DELAY: begin
				cnt_d   = '0;
				ready_d = 1'b1;
				tick_b  = kclc_pkg::sat_inc(tick_q);
				tick_d  = tick_b;
				if (tick_b > timers.start_delay) begin
					ready_d = 1'b0;
					tick_d  = '0;
					state_d = S_ENTRY;
				end
			end
			S_ENTRY: begin
				entry_d = 1'b1;
				if (press.hit) begin
					tick_b = '0;
					hist_d = CODE_BITS'({hist_q, press.digit});
					cnt_d  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
				end
				if (cnt_d >= CNT_FULL) begin
					state_d = S_CHECK;
				end
				tick_b = kclc_pkg::sat_inc(tick_b);
				tick_d = tick_b;
				// timeout wins over a code that completes in the same tick
				if (tick_b > timers.entry_timeout && cnt_d != '0) begin
					state_d = S_ALARM;
					tick_d  = '0;
				end
			end
			S_CHECK: begin
				if (hist_q == unlock_code) begin
					state_d = S_OPEN;
				end else begin
					fail_b  = (fail_q == kclc_pkg::FAIL_SAT) ? fail_q : fail_q + 1'b1;
					fail_d  = fail_b;
					state_d = (fail_b >= timers.max_fail) ? S_ALARM : S_START;
				end
			end
			S_OPEN: begin
				door_d  = 1'b1;
				entry_d = 1'b0;
				state_d = S_HOLD;
			end
			S_HOLD: begin
				tick_b = kclc_pkg::sat_inc(tick_q);
				tick_d = tick_b;
				if (tick_b > timers.open_hold) begin
					door_d  = 1'b0;
					buzz_d  = 1'b0;
					tick_d  = '0;
					state_d = S_START;
				end
			end
			S_ALARM: begin
				buzz_d = 1'b1;
				tick_b = kclc_pkg::sat_inc(tick_q);
				tick_d = tick_b;
				if (tick_b > timers.alarm) begin
					cnt_d   = '0;
					state_d = S_RENTRY;
				end
			end
			S_RENTRY: begin
				fail_d = '0;
				if (press.hit) begin
					tick_d = '0;
					hist_d = CODE_BITS'({hist_q, press.digit});
					cnt_d  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
				end
				if (cnt_d >= CNT_FULL) begin
					state_d = S_RVERIFY;
				end
			end
			S_RVERIFY: begin
				if (hist_q == reset_code) begin
					tick_b = kclc_pkg::sat_inc(tick_q);
					tick_d = tick_b;
					if (tick_b > timers.reset_hold) begin
						state_d = S_START;
					end
				end else begin
					// wrong reset code: back to entry with a fresh count
					cnt_d   = '0;
					state_d = S_RENTRY;
				end
			end
			default: begin
				buzz_d  = 1'b0;
				tick_d  = '0;
				cnt_d   = '0;
				state_d = S_DELAY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			tick_q  <= '0;
			hist_q  <= '0;
			cnt_q   <= '0;
			fail_q  <= '0;
			door_q  <= 1'b0;
			buzz_q  <= 1'b0;
			ready_q <= 1'b0;
			entry_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			tick_q  <= tick_d;
			hist_q  <= hist_d;
			cnt_q   <= cnt_d;
			fail_q  <= fail_d;
			door_q  <= door_d;
			buzz_q  <= buzz_d;
			ready_q <= ready_d;
			entry_q <= entry_d;
		end
	end

	assign status.door   = door_q;
	assign status.buzz   = buzz_q;
	assign status.ready  = ready_q;
	assign status.entry  = entry_q;
	assign status.mode   = state_q;
	assign status.digits = cnt_q[2:0];
	assign status.fails  = fail_q;

	`KCLC_ASSERT_NOW(a_door_only_hold, door_q, state_q == S_HOLD, "door open outside hold")
	`KCLC_ASSERT_NOW(a_ready_only_delay, ready_q, state_q == S_DELAY, "ready lamp outside delay")
	`KCLC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_FULL, "digit count past code length")
	`KCLC_ASSERT_NEXT(a_stall_holds, !step, $stable(state_q) && $stable(tick_q), "state moved without a step")

endmodule

[hdl/keypad_code_lock_controller.sv]
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// tick in  | in_valid / in_ready     | button_levels
// result   | out_valid / out_ready   | door_open buzzer_on ready_lamp entry_lamp
//          |                         | mode digits_entered failures
// config   | cfg_we (no wait)        | cfg_idx cfg_wdata
//
// One transaction per cycle sustained while results are taken; a tick's result passes
// through the input register, then the state and result register, and is presented
// once the result slot is free or being emptied.
// Reset is asynchronous: registers return to their defaults, the machine to start,
// button histories to all ones; no clearing pass follows.
// A stalled result holds the state; one more tick waits in the input register,
// after which in_ready drops until the result is taken.
module keypad_code_lock_controller #(
	parameter int NUM_BUTTONS  = kclc_pkg::NUM_BUTTONS_DEF,
	parameter int CODE_LENGTH  = kclc_pkg::CODE_LENGTH_DEF,
	parameter int HISTORY_BITS = kclc_pkg::HISTORY_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	// tick channel
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic [NUM_BUTTONS-1:0]                       button_levels,
	// result channel
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic                                         door_open,
	output logic                                         buzzer_on,
	output logic                                         ready_lamp,
	output logic                                         entry_lamp,
	output logic [kclc_pkg::MODE_W-1:0]                  mode,
	output logic [2:0]                                   digits_entered,
	output logic [kclc_pkg::FAIL_W-1:0]                  failures,
	// configuration
	input  logic                                         cfg_we,
	input  logic [kclc_pkg::IDX_W-1:0]                   cfg_idx,
	input  logic [((3*CODE_LENGTH > 8) ? 3*CODE_LENGTH : 8)-1:0] cfg_wdata
);

	localparam int CODE_BITS = 3 * CODE_LENGTH;
	localparam int CFG_W     = (CODE_BITS > 8) ? CODE_BITS : 8;

	logic                      valid_s1;
	logic [NUM_BUTTONS-1:0]    levels_s1;
	logic                      out_valid_q;
	logic                      adv;
	logic                      scan_en;
	logic [CODE_BITS-1:0]      unlock_code;
	logic [CODE_BITS-1:0]      reset_code;
	kclc_pkg::timers_t         timers;
	kclc_pkg::press_t          press;
	kclc_pkg::status_t         status;

	// Advance the held tick into the state whenever the result slot is free
	// or being emptied this cycle.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the payload with the transaction; no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			levels_s1 <= button_levels;
		end
	end

	kclc_cfg_regs #(
		.CODE_LENGTH (CODE_LENGTH),
		.CFG_W       (CFG_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.unlock_code (unlock_code),
		.reset_code  (reset_code),
		.timers      (timers)
	);

	// Sample the buttons only while the machine waits for digits.
	kclc_keyscan #(
		.NUM_BUTTONS  (NUM_BUTTONS),
		.HISTORY_BITS (HISTORY_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan_en (scan_en),
		.levels  (levels_s1),
		.press   (press)
	);

	kclc_core #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.press       (press),
		.unlock_code (unlock_code),
		.reset_code  (reset_code),
		.timers      (timers),
		.scan_en     (scan_en),
		.status      (status)
	);

	// The result fields are the state registers themselves.
	assign out_valid      = out_valid_q;
	assign door_open      = status.door;
	assign buzzer_on      = status.buzz;
	assign ready_lamp     = status.ready;
	assign entry_lamp     = status.entry;
	assign mode           = status.mode;
	assign digits_entered = status.digits;
	assign failures       = status.fails;

endmodule

[test/tb.sv]
module tb;

	localparam int BUTTONS     = kclc_pkg::NUM_BUTTONS_DEF;
	localparam int DIGITS      = kclc_pkg::CODE_LENGTH_DEF;
	// Cycles without any transaction before the run is declared hung
	localparam int STALL_LIMIT = 1000;

	// Machine states as reported on the mode output
	typedef enum logic [kclc_pkg::MODE_W-1:0] {
		M_START, M_DELAY, M_ENTRY, M_CHECK, M_OPEN, M_HOLD, M_ALARM, M_RENTRY, M_RVERIFY
	} lock_mode_e;

	// Lock predictor plus the queue of status words still owed by the block.
	// Ticks are noted in acceptance order; every tick owes exactly one status word.
	class lock_scoreboard;
		logic [11:0] unlock, rcode;
		logic [7:0]  t_delay, t_entry, t_open, t_alarm, t_rhold;
		logic [2:0]  max_fail;

		lock_mode_e  st;
		logic [7:0]  ticks;
		logic [2:0]  digs [DIGITS];
		logic [3:0]  dcount;
		logic [2:0]  fails;
		logic [7:0]  hist [BUTTONS];
		logic        door, buzz, ready, entry;

		kclc_pkg::status_t expected_status [$];
		int                mismatches;

		function new();
			unlock   = 12'(kclc_pkg::UNLOCK_RESET);
			rcode    = 12'(kclc_pkg::RESET_CODE_RESET);
			t_delay  = kclc_pkg::START_DELAY_RESET;
			t_entry  = kclc_pkg::ENTRY_TMO_RESET;
			t_open   = kclc_pkg::OPEN_HOLD_RESET;
			t_alarm  = kclc_pkg::ALARM_RESET;
			t_rhold  = kclc_pkg::RESET_HOLD_RESET;
			max_fail = kclc_pkg::MAX_FAIL_RESET;
			st       = M_START;
			ticks    = '0;
			dcount   = '0;
			fails    = '0;
			door     = 1'b0;
			buzz     = 1'b0;
			ready    = 1'b0;
			entry    = 1'b0;
			foreach (digs[i]) digs[i] = '0;
			foreach (hist[i]) hist[i] = 8'hFF;
			mismatches = 0;
		endfunction

		function void set_reg(logic [kclc_pkg::IDX_W-1:0] idx, logic [11:0] v);
			case (idx)
				kclc_pkg::REG_UNLOCK_CODE: unlock   = v;
				kclc_pkg::REG_RESET_CODE:  rcode    = v;
				kclc_pkg::REG_START_DELAY: t_delay  = v[7:0];
				kclc_pkg::REG_ENTRY_TMO:   t_entry  = v[7:0];
				kclc_pkg::REG_OPEN_HOLD:   t_open   = v[7:0];
				kclc_pkg::REG_ALARM:       t_alarm  = v[7:0];
				kclc_pkg::REG_RESET_HOLD:  t_rhold  = v[7:0];
				kclc_pkg::REG_MAX_FAIL:    max_fail = v[2:0];
				default: ;
			endcase
		endfunction

		// Saturating tick counter; returns the value after the step
		function logic [7:0] bump();
			if (ticks != kclc_pkg::TICK_MAX)
				ticks = ticks + 8'd1;
			return ticks;
		endfunction

		// Shift the levels into the button histories and take the winning digit
		function void take_digit(logic [3:0] lv);
			logic [2:0] d;
			int b;
			d = '0;
			for (b = 0; b < BUTTONS; b++) begin
				hist[b] = {hist[b][6:0], lv[b]};
				if (hist[b] == 8'(kclc_pkg::PRESS_PATTERN))
					d = 3'(b + 1);
			end
			if (d != 0) begin
				ticks = '0;
				for (b = 0; b < DIGITS - 1; b++)
					digs[b] = digs[b + 1];
				digs[DIGITS - 1] = d;
				if (dcount != 4'hF)
					dcount = dcount + 4'd1;
			end
		endfunction

		function logic [11:0] entered_code();
			return {digs[0], digs[1], digs[2], digs[3]};
		endfunction

		// Advance the predicted lock by one accepted tick and queue its status
		function void note_tick(logic [3:0] lv);
			logic [7:0] t;
			case (st)
				M_DELAY: begin
					dcount = '0;
					ready  = 1'b1;
					if (bump() > t_delay) begin
						ready = 1'b0;
						ticks = '0;
						st    = M_ENTRY;
					end
				end
				M_ENTRY: begin
					entry = 1'b1;
					take_digit(lv);
					if (dcount >= DIGITS)
						st = M_CHECK;
					// timeout wins over the check when both land together
					t = bump();
					if (t > t_entry && dcount != 0) begin
						st    = M_ALARM;
						ticks = '0;
					end
				end
				M_CHECK: begin
					if (entered_code() == unlock) begin
						st = M_OPEN;
					end else begin
						if (fails != kclc_pkg::FAIL_SAT)
							fails = fails + 3'd1;
						st = (fails >= max_fail) ? M_ALARM : M_START;
					end
				end
				M_OPEN: begin
					door  = 1'b1;
					entry = 1'b0;
					st    = M_HOLD;
				end
				M_HOLD: begin
					if (bump() > t_open) begin
						door  = 1'b0;
						buzz  = 1'b0;
						st    = M_START;
						ticks = '0;
					end
				end
				M_ALARM: begin
					buzz = 1'b1;
					if (bump() > t_alarm) begin
						dcount = '0;
						st     = M_RENTRY;
					end
				end
				M_RENTRY: begin
					fails = '0;
					take_digit(lv);
					if (dcount >= DIGITS)
						st = M_RVERIFY;
				end
				M_RVERIFY: begin
					if (entered_code() == rcode) begin
						if (bump() > t_rhold)
							st = M_START;
					end else begin
						dcount = '0;
						st     = M_RENTRY;
					end
				end
				default: begin
					buzz   = 1'b0;
					ticks  = '0;
					dcount = '0;
					st     = M_DELAY;
				end
			endcase
			expected_status.push_back({door, buzz, ready, entry, st, dcount[2:0], fails});
		endfunction

		function void compare_field(string name, logic [3:0] want, logic [3:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, seen);
				mismatches++;
			end
		endfunction

		function void check_status(kclc_pkg::status_t seen);
			kclc_pkg::status_t want;
			if (expected_status.size() == 0) begin
				$error("status word with no tick outstanding");
				mismatches++;
			end else begin
				want = expected_status.pop_front();
				compare_field("door_open", 4'(want.door), 4'(seen.door));
				compare_field("buzzer_on", 4'(want.buzz), 4'(seen.buzz));
				compare_field("ready_lamp", 4'(want.ready), 4'(seen.ready));
				compare_field("entry_lamp", 4'(want.entry), 4'(seen.entry));
				compare_field("mode", want.mode, seen.mode);
				compare_field("digits_entered", 4'(want.digits), 4'(seen.digits));
				compare_field("failures", 4'(want.fails), 4'(seen.fails));
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [3:0]                    button_levels;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          door_open;
	logic                          buzzer_on;
	logic                          ready_lamp;
	logic                          entry_lamp;
	logic [kclc_pkg::MODE_W-1:0]   mode;
	logic [2:0]                    digits_entered;
	logic [kclc_pkg::FAIL_W-1:0]   failures;
	logic                          cfg_we;
	logic [kclc_pkg::IDX_W-1:0]    cfg_idx;
	logic [11:0]                   cfg_wdata;

	lock_scoreboard sb;
	int             send_idle_pct;
	int             take_idle_pct;
	int             ticks_sent;
	int             stalled = 0;

	keypad_code_lock_controller dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_levels  (button_levels),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.door_open      (door_open),
		.buzzer_on      (buzzer_on),
		.ready_lamp     (ready_lamp),
		.entry_lamp     (entry_lamp),
		.mode           (mode),
		.digits_entered (digits_entered),
		.failures       (failures),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: check each status transaction at the edge that takes it,
	// then decide whether to stall the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_status({door_open, buzzer_on, ready_lamp, entry_lamp, mode,
				digits_entered, failures});
		out_ready <= ($urandom_range(99) >= take_idle_pct);
	end

	// Watchdog: count cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stalled <= 0;
		end else if (stalled < STALL_LIMIT) begin
			stalled <= stalled + 1;
		end else begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one tick, hold it until taken, then maybe idle before the next.
	// Valid is only dropped when an idle gap follows, so back-to-back ticks
	// never see a low and a high scheduled in the same step.
	task automatic send_tick(input logic [3:0] lv);
		in_valid      <= 1'b1;
		button_levels <= lv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tick(lv);
		ticks_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Drop valid and wait until every outstanding status word has been taken
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_status.size() != 0)
			@(posedge clk);
	endtask

	// One register write per cycle; the enable stays high across a burst
	task automatic write_reg(input logic [kclc_pkg::IDX_W-1:0] idx, input logic [11:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic program_lock(input logic [11:0] unl, input logic [11:0] rc,
			input logic [7:0] sd, input logic [7:0] et, input logic [7:0] oh,
			input logic [7:0] al, input logic [7:0] rh, input logic [2:0] mf);
		write_reg(kclc_pkg::REG_UNLOCK_CODE, unl);
		write_reg(kclc_pkg::REG_RESET_CODE, rc);
		write_reg(kclc_pkg::REG_START_DELAY, {4'h0, sd});
		write_reg(kclc_pkg::REG_ENTRY_TMO, {4'h0, et});
		write_reg(kclc_pkg::REG_OPEN_HOLD, {4'h0, oh});
		write_reg(kclc_pkg::REG_ALARM, {4'h0, al});
		write_reg(kclc_pkg::REG_RESET_HOLD, {4'h0, rh});
		write_reg(kclc_pkg::REG_MAX_FAIL, {9'h000, mf});
		cfg_we <= 1'b0;
	endtask

	// Mostly codes made of reachable digits; now and then the all-zero or
	// all-ones pattern, which no button sequence can ever match
	function automatic logic [11:0] random_code();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 12'h000;
		if (r == 1)
			return 12'hFFF;
		return {3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)),
			3'($urandom_range(1, 4)), 3'($urandom_range(1, 4))};
	endfunction

	// One stretch of random traffic under a fresh register setting.
	// kind 0: moderate timers; kind 1: all timers at zero and a failure limit of one;
	// kind 2: long entry and hold timers, the others long or short, and the highest failure limit.
	task automatic run_segment(input int kind, input int n);
		logic [7:0]  sd, et, oh, al, rh;
		logic [2:0]  mf, d;
		logic [11:0] code;
		logic [3:0]  mask;
		int          stop, pos;
		settle();
		case (kind)
			0: begin
				sd = 8'($urandom_range(20));
				et = 8'($urandom_range(12, 60));
				oh = 8'($urandom_range(20));
				al = 8'($urandom_range(20));
				rh = 8'($urandom_range(20));
				mf = 3'($urandom_range(1, 7));
			end
			1: begin
				sd = 8'd0;
				et = 8'd0;
				oh = 8'd0;
				al = 8'd0;
				rh = 8'd0;
				mf = 3'd1;
			end
			default: begin
				sd = $urandom_range(1) ? 8'd254 : 8'($urandom_range(5));
				et = 8'd254;
				oh = 8'd254;
				al = $urandom_range(1) ? 8'd254 : 8'($urandom_range(10));
				rh = $urandom_range(1) ? 8'd254 : 8'($urandom_range(10));
				mf = 3'd7;
			end
		endcase
		program_lock(random_code(), random_code(), sd, et, oh, al, rh, mf);
		stop = ticks_sent + n;
		while (ticks_sent < stop) begin
			if ((sb.st == M_ENTRY || sb.st == M_RENTRY) && $urandom_range(9) != 0) begin
				// Aim for the next digit of whichever code is being keyed,
				// otherwise a random button
				code = (sb.st == M_RENTRY) ? sb.rcode : sb.unlock;
				pos  = DIGITS - 1 - int'(sb.dcount);
				d    = (pos >= 0) ? code[3*pos +: 3] : 3'd0;
				if (d == 0 || d > 4 || $urandom_range(99) >= 75)
					d = 3'($urandom_range(1, 4));
				// Release for six or more ticks, with the odd glitch to break
				// the pattern, then press; lower buttons may join in and lose
				repeat (6 + $urandom_range(3))
					send_tick(($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'h0);
				mask = (4'b0001 << (d - 1)) | (4'($urandom) & ((4'b0001 << (d - 1)) - 4'd1));
				repeat (2 + $urandom_range(2))
					send_tick(mask);
			end else begin
				// Noise, or ticks the machine only counts
				send_tick(4'($urandom_range(15)));
			end
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		button_levels = 4'h0;
		cfg_we        = 1'b0;
		cfg_idx       = kclc_pkg::REG_UNLOCK_CODE;
		cfg_wdata     = 12'h000;
		send_idle_pct = 9;
		take_idle_pct = 53;
		ticks_sent    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no start delay, so entry opens on the second tick; then a
		// press of every button at once (highest wins) and a lone lowest button
		program_lock(12'h924, 12'h249, 8'd0, 8'd254, 8'd0, 8'd0, 8'd0, 3'd1);
		repeat (8) send_tick(4'h0);
		repeat (2) send_tick(4'hF);
		repeat (6) send_tick(4'h0);
		repeat (2) send_tick(4'h1);

		// Three idling regimes, each with every kind of register setting
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 9;
					take_idle_pct = 53;
				end
				1: begin
					send_idle_pct = 53;
					take_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
				end
			endcase
			run_segment(0, 120);
			run_segment(1, 120);
			run_segment(2, 210);
		end

		// Drain, then keep the clock running so that any stray result would show
		settle();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
